FILE: hw/rtl/uer_pkg.sv
// Package for the ultrasonic echo ranger: phase and error codes, register
// indexes, field widths and the distance scale constants.
// No dependencies.
package uer_pkg;

    localparam int CNT_W      = 24;   // phase counter, wide enough for the gap
    localparam int TMO_W      = 12;
    localparam int TRIG_W     = 8;
    localparam int CM_W       = 7;
    localparam int DIST_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // 0.0343 cm/us in Q8 after a >>6: 562 / 64 ~= 0.0343 * 256
    localparam int SCALE_SHIFT = 6;
    localparam logic [9:0] SCALE_MUL = 10'd562;

    typedef enum logic [2:0] {
        PH_GAP   = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_RISE  = 3'd3,
        PH_WIDTH = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NO_RISE = 2'd1,
        ERR_NO_FALL = 2'd2
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_TIMEOUT = 3'd0,
        CFG_TRIG_HIGH    = 3'd1,
        CFG_TRIG_LOW     = 3'd2,
        CFG_REPEAT_GAP   = 3'd3,
        CFG_RANGE_MIN    = 3'd4,
        CFG_RANGE_MAX    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              trigger_level;
        logic              measure_done;
        t_err              error_code;
        logic [DIST_W-1:0] distance_q8;
        logic              distance_valid;
        logic              in_window;
    } t_result;

endpackage

FILE: hw/rtl/uer_if.sv
// Channel interfaces of the echo ranger: tick input, result output and
// configuration write. Depends on uer_pkg.
interface uer_in_if import uer_pkg::*; ();
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              measure_done;
    logic [1:0]        error_code;
    logic [DIST_W-1:0] distance_q8;
    logic              distance_valid;
    logic              in_window;

    modport source (output valid, output trigger_level, output measure_done,
                    output error_code, output distance_q8, output distance_valid,
                    output in_window, input ready);
    modport sink   (input valid, input trigger_level, input measure_done,
                    input error_code, input distance_q8, input distance_valid,
                    input in_window, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger, top level. One input transfer is one microsecond
// tick carrying the sampled echo pin; each tick produces exactly one result
// transfer with the trigger level, a done pulse, the error code and the last
// distance. Throughput is one tick per clock while the output is not stalled:
// the tick is decoded and the result written to the output register in the
// cycle of its transfer. The input is stalled only while the output register
// holds a result that the sink has not taken. Configuration writes are never
// stalled and should be issued while no tick is in flight.
// Depends on uer_pkg and uer_if.
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    uer_in_if.sink     i_in,
    uer_out_if.source  o_out,
    uer_cfg_if.sink    i_cfg
);

    // configuration
    logic [TMO_W-1:0]  r_echo_timeout;
    logic [TRIG_W-1:0] r_trig_high;
    logic [TRIG_W-1:0] r_trig_low;
    logic [CNT_W-1:0]  r_repeat_gap;
    logic [CM_W-1:0]   r_range_min;
    logic [CM_W-1:0]   r_range_max;

    // measurement state
    t_phase            r_phase,     n_phase;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [DIST_W-1:0] r_last_dist, n_last_dist;
    logic              r_last_valid, n_last_valid;

    // output register
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              in_accept;
    t_phase            ph;
    logic [CNT_W-1:0]  cnt;
    logic              timed_out;
    logic [20:0]       scaled;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_timeout <= TMO_W'(3000);
            r_trig_high    <= TRIG_W'(10);
            r_trig_low     <= TRIG_W'(2);
            r_repeat_gap   <= CNT_W'(1000000);
            r_range_min    <= CM_W'(10);
            r_range_max    <= CM_W'(16);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ECHO_TIMEOUT: r_echo_timeout <= i_cfg.data[TMO_W-1:0];
                CFG_TRIG_HIGH:    r_trig_high    <= i_cfg.data[TRIG_W-1:0];
                CFG_TRIG_LOW:     r_trig_low     <= i_cfg.data[TRIG_W-1:0];
                CFG_REPEAT_GAP:   r_repeat_gap   <= i_cfg.data;
                CFG_RANGE_MIN:    r_range_min    <= i_cfg.data[CM_W-1:0];
                CFG_RANGE_MAX:    r_range_max    <= i_cfg.data[CM_W-1:0];
                default: ;
            endcase
        end
    end

    // echo width is at most the 12-bit timeout; halve, then scale to Q8 cm
    assign scaled = 21'(r_count[TMO_W-1:1]) * 21'(SCALE_MUL);

    always_comb begin
        ph           = (r_phase > PH_WIDTH) ? PH_GAP : r_phase;
        cnt          = r_count;
        n_last_dist  = r_last_dist;
        n_last_valid = r_last_valid;
        n_out        = '0;

        // zero-length phases fall through within the same tick
        if (ph == PH_GAP && cnt == '0) begin
            ph  = PH_LOW;
            cnt = CNT_W'(r_trig_low);
        end
        if (ph == PH_LOW && cnt == '0) begin
            ph  = PH_HIGH;
            cnt = CNT_W'(r_trig_high);
        end
        if (ph == PH_HIGH && cnt == '0) begin
            ph  = PH_RISE;
            cnt = '0;
        end

        timed_out = (cnt >= CNT_W'(r_echo_timeout));
        n_phase   = ph;
        n_count   = cnt;

        case (ph)
            PH_GAP, PH_LOW: begin
                n_count = cnt - 1'b1;
            end
            PH_HIGH: begin
                n_out.trigger_level = 1'b1;
                n_count             = cnt - 1'b1;
            end
            PH_RISE: begin
                if (timed_out) begin
                    n_out.measure_done = 1'b1;
                    n_out.error_code   = ERR_NO_RISE;
                    n_last_dist        = '0;
                    n_last_valid       = 1'b0;
                    n_phase            = PH_GAP;
                    n_count            = r_repeat_gap;
                end else if (i_in.echo_level) begin
                    n_phase = PH_WIDTH;
                    n_count = CNT_W'(1);
                end else begin
                    n_count = cnt + 1'b1;
                end
            end
            PH_WIDTH: begin
                if (!i_in.echo_level) begin
                    n_out.measure_done = 1'b1;
                    n_out.error_code   = ERR_OK;
                    n_last_dist        = scaled[SCALE_SHIFT +: DIST_W];
                    n_last_valid       = 1'b1;
                    n_phase            = PH_GAP;
                    n_count            = r_repeat_gap;
                end else if (timed_out) begin
                    n_out.measure_done = 1'b1;
                    n_out.error_code   = ERR_NO_FALL;
                    n_last_dist        = '0;
                    n_last_valid       = 1'b0;
                    n_phase            = PH_GAP;
                    n_count            = r_repeat_gap;
                end else begin
                    n_count = cnt + 1'b1;
                end
            end
            default: ;
        endcase

        n_out.distance_q8    = n_last_dist;
        n_out.distance_valid = n_last_valid;
        n_out.in_window      = n_last_valid
                            && (n_last_dist >= {r_range_min, 8'd0})
                            && (n_last_dist <= {r_range_max, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_GAP;
            r_count      <= '0;
            r_last_dist  <= '0;
            r_last_valid <= 1'b0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_last_dist  <= n_last_dist;
            r_last_valid <= n_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.trigger_level  = r_out.trigger_level;
    assign o_out.measure_done   = r_out.measure_done;
    assign o_out.error_code     = r_out.error_code;
    assign o_out.distance_q8    = r_out.distance_q8;
    assign o_out.distance_valid = r_out.distance_valid;
    assign o_out.in_window      = r_out.in_window;

`ifndef SYNTHESIS
    // a held result blocks new ticks
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result is stalled");

    // echo falling during the width count ends the measurement with a distance
    a_fall_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_WIDTH && !i_in.echo_level)
        |=> (r_out_valid && r_out.measure_done && r_out.error_code == ERR_OK
             && r_out.distance_valid && r_phase == PH_GAP))
        else $error("echo fall did not finish measurement");

    // a rise timeout clears the stored distance
    a_rise_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_RISE && r_count >= CNT_W'(r_echo_timeout))
        |=> (r_out.error_code == ERR_NO_RISE && !r_last_valid && r_last_dist == '0))
        else $error("rise timeout not reported");
`endif

endmodule
